// ===== hw/rtl/ots_pkg.sv =====
// Shared types, register indexes and tactic helpers for the overtake tactic selector.
package ots_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_DIST = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERTAKE_DIST = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_DONE_DIST = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFEND_DIST = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_MARGIN = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_LIMIT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMES = 4'd7;

    // Fixed-point constants (8 fraction bits)
    localparam logic [23:0] DEFAULT_WRAP = 24'd51200;
    localparam logic [19:0] TIMER_MAX = 20'hFFFFF;
    // own speed above 0.1 m/s: 10*v > 256 holds from 26 on
    localparam logic [15:0] MIN_OWN_SPEED = 16'd26;
    // closing speed above 0.2 m/s: 10*c > 512 holds from 52 on
    localparam logic signed [17:0] MIN_CLOSING = 18'sd52;

    // Output codes
    typedef enum logic [2:0] {
        TAC_SOLO   = 3'd0,
        TAC_FOLLOW = 3'd1,
        TAC_LEFT   = 3'd2,
        TAC_RIGHT  = 3'd3,
        TAC_DEFEND = 3'd4
    } t_tactic;

    typedef enum logic [1:0] {
        LINE_OPTIMAL   = 2'd0,
        LINE_DEFENSIVE = 2'd1,
        LINE_INSIDE    = 2'd2,
        LINE_OUTSIDE   = 2'd3
    } t_line;

    // Tactic state, one-hot
    typedef enum logic [4:0] {
        ST_SOLO   = 5'b00001,
        ST_FOLLOW = 5'b00010,
        ST_LEFT   = 5'b00100,
        ST_RIGHT  = 5'b01000,
        ST_DEFEND = 5'b10000
    } t_tstate;

    typedef struct packed {
        logic [23:0] lap_length;
        logic [15:0] follow_distance;
        logic [15:0] overtake_distance;
        logic [15:0] pass_complete_distance;
        logic [15:0] defend_distance;
        logic [15:0] lateral_margin;
        logic [15:0] contact_time_limit;
        logic [15:0] hold_general;
        logic [15:0] hold_entry;
        logic [15:0] hold_exit;
    } t_cfg;

    typedef struct packed {
        logic [23:0] own_position;
        logic [15:0] own_offset;
        logic [15:0] own_speed;
        logic        rival_present;
        logic [23:0] rival_position;
        logic [15:0] rival_offset;
        logic [15:0] rival_speed;
        logic [15:0] elapsed;
        logic        force_solo;
    } t_item;

    function automatic logic is_overtake(input t_tstate s);
        return (s == ST_LEFT) || (s == ST_RIGHT);
    endfunction

    function automatic t_tactic tactic_code(input t_tstate s);
        t_tactic c;
        case (s)
            ST_SOLO:   c = TAC_SOLO;
            ST_FOLLOW: c = TAC_FOLLOW;
            ST_LEFT:   c = TAC_LEFT;
            ST_RIGHT:  c = TAC_RIGHT;
            ST_DEFEND: c = TAC_DEFEND;
            default:   c = TAC_SOLO;
        endcase
        return c;
    endfunction

    function automatic t_line line_of(input logic [2:0] code);
        t_line l;
        case (code)
            TAC_FOLLOW: l = LINE_DEFENSIVE;
            TAC_LEFT:   l = LINE_INSIDE;
            TAC_RIGHT:  l = LINE_OUTSIDE;
            TAC_DEFEND: l = LINE_DEFENSIVE;
            default:    l = LINE_OPTIMAL;
        endcase
        return l;
    endfunction

endpackage

// ===== hw/rtl/ots_cfg.sv =====
// Configuration register file of the overtake tactic selector.
module ots_cfg import ots_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Write one register; indexes beyond the list drop the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lap_length             <= DEFAULT_WRAP;
            r_cfg.follow_distance        <= 16'd2560;
            r_cfg.overtake_distance      <= 16'd1280;
            r_cfg.pass_complete_distance <= 16'd512;
            r_cfg.defend_distance        <= 16'd2560;
            r_cfg.lateral_margin         <= 16'd128;
            r_cfg.contact_time_limit     <= 16'd0;
            r_cfg.hold_general           <= 16'd0;
            r_cfg.hold_entry             <= 16'd0;
            r_cfg.hold_exit              <= 16'd0;
        end else if (i_wr) begin
            case (i_index)
                CFG_TRACK_LENGTH:   r_cfg.lap_length <= i_data[23:0];
                CFG_FOLLOW_DIST:    r_cfg.follow_distance <= i_data[15:0];
                CFG_OVERTAKE_DIST:  r_cfg.overtake_distance <= i_data[15:0];
                CFG_PASS_DONE_DIST: r_cfg.pass_complete_distance <= i_data[15:0];
                CFG_DEFEND_DIST:    r_cfg.defend_distance <= i_data[15:0];
                CFG_LATERAL_MARGIN: r_cfg.lateral_margin <= i_data[15:0];
                CFG_CONTACT_LIMIT:  r_cfg.contact_time_limit <= i_data[15:0];
                CFG_HOLD_TIMES: begin
                    r_cfg.hold_general <= i_data[15:0];
                    r_cfg.hold_entry   <= i_data[31:16];
                    r_cfg.hold_exit    <= i_data[47:32];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/ots_want.sv =====
// Desired tactic from the registered tick: track gap, contact trigger and side choice.
module ots_want import ots_pkg::*; (
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    input  t_tstate i_cur,
    output t_tstate o_want
);

    logic signed [27:0] wrap;
    logic signed [27:0] gap_raw;
    logic signed [27:0] gap_a;
    logic signed [27:0] gap;
    logic signed [27:0] fd;
    logic signed [27:0] pcd;
    logic signed [27:0] dd;
    logic [15:0]        gap16;
    logic signed [17:0] closing;
    logic [32:0]        contact_prod;
    logic               fire;
    logic               near;
    logic signed [17:0] own_off;
    logic signed [17:0] riv_off;
    logic signed [17:0] margin;
    logic               go_left;
    logic               go_right;
    logic               ahead_close;
    logic               behind_close;

    // Wrap the gap into half a lap either way
    always_comb begin
        wrap = (i_cfg.lap_length == 24'd0) ? $signed({4'b0, DEFAULT_WRAP})
                                           : $signed({4'b0, i_cfg.lap_length});
        gap_raw = $signed({4'b0, i_item.rival_position}) - $signed({4'b0, i_item.own_position});
        gap_a = ((gap_raw <<< 1) > wrap) ? gap_raw - wrap : gap_raw;
        gap   = ((gap_a <<< 1) < -wrap) ? gap_a + wrap : gap_a;
    end

    assign fd  = $signed({12'b0, i_cfg.follow_distance});
    assign pcd = $signed({12'b0, i_cfg.pass_complete_distance});
    assign dd  = $signed({12'b0, i_cfg.defend_distance});

    assign ahead_close  = (gap > 28'sd0) && (gap < fd);
    assign behind_close = (gap < 28'sd0) && (gap > -dd);
    assign gap16 = gap[15:0];

    // Time to contact: 256*gap < limit*closing, no division
    assign closing = $signed({2'b0, i_item.own_speed})
                   - $signed({{2{i_item.rival_speed[15]}}, i_item.rival_speed});
    assign contact_prod = i_cfg.contact_time_limit * closing[16:0];
    assign fire = (i_cfg.contact_time_limit != 16'd0)
               && (i_item.own_speed >= MIN_OWN_SPEED)
               && (closing >= MIN_CLOSING)
               && ({9'b0, gap16, 8'b0} < contact_prod);
    // A triggered contact counts as near whenever the overtake distance is nonzero
    assign near = fire ? (i_cfg.overtake_distance != 16'd0)
                       : (gap16 < i_cfg.overtake_distance);

    // Pick a side with enough lateral room
    assign own_off = $signed({{2{i_item.own_offset[15]}}, i_item.own_offset});
    assign riv_off = $signed({{2{i_item.rival_offset[15]}}, i_item.rival_offset});
    assign margin  = $signed({2'b0, i_cfg.lateral_margin});
    assign go_left  = own_off < (riv_off - margin);
    assign go_right = own_off > (riv_off + margin);

    always_comb begin
        if (!i_item.rival_present) begin
            o_want = ST_SOLO;
        end else if (is_overtake(i_cur)) begin
            if ((gap < -pcd) || (gap > fd)) begin
                o_want = ST_SOLO;
            end else begin
                o_want = i_cur;
            end
        end else if (ahead_close) begin
            if (near && go_left) begin
                o_want = ST_LEFT;
            end else if (near && go_right) begin
                o_want = ST_RIGHT;
            end else begin
                o_want = ST_FOLLOW;
            end
        end else if (behind_close) begin
            o_want = ST_DEFEND;
        end else begin
            o_want = ST_SOLO;
        end
    end

endmodule

// ===== hw/rtl/ots_hold.sv =====
// Tactic state with pending target and saturating hold timer.
module ots_hold import ots_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_force,
    input  logic [15:0] i_elapsed,
    input  t_tstate     i_want,
    input  t_cfg        i_cfg,
    output t_tstate     o_cur,
    output t_tstate     o_next
);

    t_tstate     r_cur;
    t_tstate     r_pend;
    logic [19:0] r_timer;
    t_tstate     n_cur;
    t_tstate     n_pend;
    logic [19:0] n_timer;
    logic [19:0] base;
    logic [20:0] sum;
    logic [19:0] sat;
    logic [15:0] hold;

    // Restart the timer when the target changes, then add and saturate
    assign base = (i_want != r_pend) ? 20'd0 : r_timer;
    assign sum  = {1'b0, base} + {5'b0, i_elapsed};
    assign sat  = sum[20] ? TIMER_MAX : sum[19:0];

    // Pick hold by transition kind
    always_comb begin
        if (is_overtake(i_want)) begin
            hold = i_cfg.hold_entry;
        end else if (is_overtake(r_cur)) begin
            hold = i_cfg.hold_exit;
        end else begin
            hold = i_cfg.hold_general;
        end
    end

    always_comb begin
        n_cur   = r_cur;
        n_pend  = r_pend;
        n_timer = r_timer;
        if (i_force) begin
            n_cur   = ST_SOLO;
            n_pend  = ST_SOLO;
            n_timer = 20'd0;
        end else if (i_want != r_cur) begin
            n_pend = i_want;
            if (sat >= {4'b0, hold}) begin
                n_cur   = i_want;
                n_timer = 20'd0;
            end else begin
                n_timer = sat;
            end
        end else begin
            n_pend  = r_cur;
            n_timer = 20'd0;
        end
    end

    // Advance state once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= ST_SOLO;
            r_pend  <= ST_SOLO;
            r_timer <= 20'd0;
        end else if (i_step) begin
            r_cur   <= n_cur;
            r_pend  <= n_pend;
            r_timer <= n_timer;
        end
    end

    assign o_cur  = r_cur;
    assign o_next = n_cur;

`ifndef NO_ASSERTIONS
    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == r_cur) |-> (r_timer == 20'd0))
        else $error("hold timer running with no pending change");
    a_step_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_force && (i_want == r_cur)) |=> (r_timer == 20'd0))
        else $error("hold timer not cleared while tactic unchanged");
    a_force_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_force) |=> ((r_cur == ST_SOLO) && (r_timer == 20'd0)))
        else $error("forced tick did not clear the tactic state");
`endif

endmodule

// ===== hw/rtl/overtake_tactic_selector.sv =====
// Top level of the overtake tactic selector: tick register, decision and result register.
//
//   channel  direction  handshake              payload
//   input    in         i_valid / o_stall      i_own_* , i_rival_* , i_elapsed, i_force_solo
//   result   out        o_valid / i_stall      o_tactic, o_line_choice
//   config   in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One word per clock sustained while i_stall stays low; a taken tick passes through the tick
// register, one decision pass and the result register.
// Synchronous active-low reset restores the register defaults and solo racing.
// A stalled result holds in its register while one more tick waits in the tick register;
// o_stall rises only when both are full.
module overtake_tactic_selector import ots_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [23:0]           i_own_position,
    input  logic signed [15:0]    i_own_offset,
    input  logic [15:0]           i_own_speed,
    input  logic                  i_rival_present,
    input  logic [23:0]           i_rival_position,
    input  logic signed [15:0]    i_rival_offset,
    input  logic signed [15:0]    i_rival_speed,
    input  logic [15:0]           i_elapsed,
    input  logic                  i_force_solo,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_tactic,
    output logic [1:0]            o_line_choice,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_vld;
    logic    r_out_vld;
    logic [2:0] r_tactic;
    logic [1:0] r_line;
    logic    in_acc;
    logic    out_free;
    logic    step;
    t_tstate cur;
    t_tstate want;
    t_tstate next_cur;
    t_tactic next_code;

    assign o_cfg_ready = 1'b1;

    ots_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Handshake: tick register feeds result register
    assign out_free = !r_out_vld || !i_stall;
    assign step     = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign in_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Capture the tick word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.own_position   <= i_own_position;
            r_in.own_offset     <= i_own_offset;
            r_in.own_speed      <= i_own_speed;
            r_in.rival_present  <= i_rival_present;
            r_in.rival_position <= i_rival_position;
            r_in.rival_offset   <= i_rival_offset;
            r_in.rival_speed    <= i_rival_speed;
            r_in.elapsed        <= i_elapsed;
            r_in.force_solo     <= i_force_solo;
        end
    end

    ots_want u_want (
        .i_item (r_in),
        .i_cfg  (cfg),
        .i_cur  (cur),
        .o_want (want)
    );

    ots_hold u_hold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_force   (r_in.force_solo),
        .i_elapsed (r_in.elapsed),
        .i_want    (want),
        .i_cfg     (cfg),
        .o_cur     (cur),
        .o_next    (next_cur)
    );

    // Load the result word
    assign next_code = tactic_code(next_cur);

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_tactic <= next_code;
            r_line   <= line_of(next_code);
        end
    end

    assign o_valid       = r_out_vld;
    assign o_tactic      = r_tactic;
    assign o_line_choice = r_line;

`ifndef NO_ASSERTIONS
    a_line_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_line_choice == line_of(o_tactic)))
        else $error("raceline code does not match tactic");
    a_force_solo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in.force_solo) |=> (o_valid && (o_tactic == TAC_SOLO)))
        else $error("forced tick did not yield solo");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !step) |=> r_in_vld)
        else $error("waiting tick dropped");
`endif

endmodule
